### src/ilt_pkg.sv
// indexed list table: shared constants, operation codes and word types
// used by indexed_list_table_top; no dependencies
package ilt_pkg;

  localparam int CAPACITY     = 64;
  localparam int ELEMENT_BITS = 16;
  localparam int CNT_W        = 7;
  localparam int ADDR_W       = $clog2(CAPACITY);
  localparam int OP_W         = 4;

  localparam logic [OP_W-1:0] OP_ADD          = 4'd0;
  localparam logic [OP_W-1:0] OP_INSERT       = 4'd1;
  localparam logic [OP_W-1:0] OP_GET          = 4'd2;
  localparam logic [OP_W-1:0] OP_SET          = 4'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_AT    = 4'd4;
  localparam logic [OP_W-1:0] OP_REMOVE_VALUE = 4'd5;
  localparam logic [OP_W-1:0] OP_REMOVE_RANGE = 4'd6;
  localparam logic [OP_W-1:0] OP_FIRST_INDEX  = 4'd7;
  localparam logic [OP_W-1:0] OP_LAST_INDEX   = 4'd8;
  localparam logic [OP_W-1:0] OP_CONTAINS     = 4'd9;
  localparam logic [OP_W-1:0] OP_CLEAR        = 4'd10;
  localparam logic [OP_W-1:0] OP_SET_SIZE     = 4'd11;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [CNT_W-1:0]        index;
    logic [CNT_W-1:0]        range_end;
    logic [CNT_W-1:0]        new_size;
    logic [ELEMENT_BITS-1:0] element;
  } req_t;

  typedef struct packed {
    logic                    ok;
    logic [ELEMENT_BITS-1:0] value;
    logic [CNT_W-1:0]        position;
    logic [CNT_W-1:0]        count;
  } rsp_t;

endpackage

### src/indexed_list_table_top.sv
// indexed list table: ordered list of handles held in one synchronous ram
// with a sequencer that shifts, searches and fills one entry per cycle
// depends on ilt_pkg
//
// usage:
//   request channel req / req_valid / req_stall carries one operation word;
//   response channel rsp / rsp_valid / rsp_stall returns exactly one word
//   per request (ok, value, position, count after the request).
//   one request is worked at a time; req_stall is high from acceptance
//   until the result has been moved into the output register.
// steps per operation, n = entry count:
//   add, clear, failed checks, shrinking set_size: straight to the output stage
//   get, set: one ram read of entry i; set then writes the new element
//   insert at i: entries i .. n-1 shift up by one, top first, then the write
//   remove_at i: entries above i shift down by one
//   remove_range [from, to): entries from to upward shift down to from
//   searches: scan entry by entry; remove_value then shifts as remove_at
//   growing set_size: entries n .. new_size-1 are written with zero
// the ram has a single read and a single write port: each
// shift step reads one entry and writes one entry per cycle.
// the next request can be taken while a result waits in the output register.
// reset empties the list (count 0) and drops any pending response; entry
// contents stay undefined until written. a stalled response holds and the
// block stops after finishing at most one more request.
module indexed_list_table_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ilt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ilt_pkg::rsp_t rsp
);
  import ilt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SHUP = 3'd1;
  localparam logic [2:0] S_SHDN = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_FILL = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic [ELEMENT_BITS-1:0] mem [CAPACITY];
  logic [ELEMENT_BITS-1:0] rdata;
  logic                    mem_we, mem_re;
  logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
  logic [ELEMENT_BITS-1:0] mem_wdata;

  logic [2:0]              state, state_next;
  logic [OP_W-1:0]         op, op_next;
  logic [ELEMENT_BITS-1:0] elem, elem_next;
  logic [CNT_W-1:0]        idx, idx_next;
  logic [CNT_W-1:0]        lim, lim_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [CNT_W-1:0]        rp, rp_next;
  logic [CNT_W-1:0]        wp, wp_next;
  logic                    pend, pend_next;
  logic [CNT_W-1:0]        pend_addr, pend_addr_next;
  logic                    res_ok, res_ok_next;
  logic [ELEMENT_BITS-1:0] res_value, res_value_next;
  logic [CNT_W-1:0]        res_pos, res_pos_next;
  logic                    rsp_valid_next;
  rsp_t                    rsp_next;

  logic [CNT_W-1:0] rp_dec, rp_inc, wp_inc, pend_inc;
  logic             hit;

  assign rp_dec   = rp - 1'b1;
  assign rp_inc   = rp + 1'b1;
  assign wp_inc   = wp + 1'b1;
  assign pend_inc = pend_addr + 1'b1;
  assign hit      = pend && (rdata == elem);

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    elem_next      = elem;
    idx_next       = idx;
    lim_next       = lim;
    count_next     = count;
    rp_next        = rp;
    wp_next        = wp;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    res_ok_next    = res_ok;
    res_value_next = res_value;
    res_pos_next   = res_pos;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next        = req.operation;
          elem_next      = req.element;
          idx_next       = req.index;
          res_ok_next    = 1'b0;
          res_value_next = '0;
          res_pos_next   = '0;
          state_next     = S_DONE;
          case (req.operation)
            OP_ADD: begin
              if (count < CAP_C) begin
                mem_we      = 1'b1;
                mem_waddr   = count[ADDR_W-1:0];
                mem_wdata   = req.element;
                count_next  = count + 1'b1;
                res_ok_next = 1'b1;
              end
            end
            OP_INSERT: begin
              if (count < CAP_C && req.index <= count) begin
                rp_next    = count;
                state_next = S_SHUP;
              end
            end
            OP_GET, OP_SET: begin
              if (req.index < count) begin
                mem_re     = 1'b1;
                mem_raddr  = req.index[ADDR_W-1:0];
                state_next = S_READ;
              end
            end
            OP_REMOVE_AT: begin
              if (req.index < count) begin
                wp_next    = req.index;
                rp_next    = req.index + 1'b1;
                state_next = S_SHDN;
              end
            end
            OP_REMOVE_RANGE: begin
              if (req.index < req.range_end && req.range_end <= count) begin
                wp_next    = req.index;
                rp_next    = req.range_end;
                state_next = S_SHDN;
              end
            end
            OP_REMOVE_VALUE, OP_CONTAINS: begin
              rp_next    = '0;
              state_next = S_SCAN;
            end
            OP_FIRST_INDEX: begin
              rp_next      = '0;
              res_pos_next = count;
              state_next   = S_SCAN;
            end
            OP_LAST_INDEX: begin
              rp_next      = count;
              res_pos_next = count;
              state_next   = S_SCAN;
            end
            OP_CLEAR: begin
              count_next  = '0;
              res_ok_next = 1'b1;
            end
            OP_SET_SIZE: begin
              if (req.new_size < count) begin
                count_next  = req.new_size;
                res_ok_next = 1'b1;
              end else if (req.new_size <= CAP_C) begin
                wp_next    = count;
                lim_next   = req.new_size;
                state_next = S_FILL;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // move entries up by one, top first
      S_SHUP: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_inc[ADDR_W-1:0];
          mem_wdata = rdata;
        end
        if (rp > idx) begin
          mem_re         = 1'b1;
          mem_raddr      = rp_dec[ADDR_W-1:0];
          rp_next        = rp_dec;
          pend_next      = 1'b1;
          pend_addr_next = rp_dec;
        end else if (!pend) begin
          mem_we      = 1'b1;
          mem_waddr   = idx[ADDR_W-1:0];
          mem_wdata   = elem;
          count_next  = count + 1'b1;
          res_ok_next = 1'b1;
          state_next  = S_DONE;
        end
      end

      // move entries down by the gap rp - wp
      S_SHDN: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = wp[ADDR_W-1:0];
          mem_wdata = rdata;
          wp_next   = wp_inc;
        end
        if (rp < count) begin
          mem_re    = 1'b1;
          mem_raddr = rp[ADDR_W-1:0];
          rp_next   = rp_inc;
          pend_next = 1'b1;
        end else if (!pend) begin
          count_next  = wp;
          res_ok_next = 1'b1;
          state_next  = S_DONE;
        end
      end

      S_SCAN: begin
        if (hit) begin
          case (op)
            OP_REMOVE_VALUE: begin
              wp_next    = pend_addr;
              rp_next    = pend_inc;
              state_next = S_SHDN;
            end
            OP_FIRST_INDEX, OP_LAST_INDEX: begin
              res_pos_next = pend_addr;
              res_ok_next  = 1'b1;
              state_next   = S_DONE;
            end
            default: begin
              res_ok_next = 1'b1;
              state_next  = S_DONE;
            end
          endcase
        end else if (op == OP_LAST_INDEX && rp != '0) begin
          mem_re         = 1'b1;
          mem_raddr      = rp_dec[ADDR_W-1:0];
          rp_next        = rp_dec;
          pend_next      = 1'b1;
          pend_addr_next = rp_dec;
        end else if (op != OP_LAST_INDEX && rp < count) begin
          mem_re         = 1'b1;
          mem_raddr      = rp[ADDR_W-1:0];
          rp_next        = rp_inc;
          pend_next      = 1'b1;
          pend_addr_next = rp;
        end else if (!pend) begin
          state_next = S_DONE;
        end
      end

      S_READ: begin
        res_value_next = rdata;
        res_ok_next    = 1'b1;
        if (op == OP_SET) begin
          mem_we    = 1'b1;
          mem_waddr = idx[ADDR_W-1:0];
          mem_wdata = elem;
        end
        state_next = S_DONE;
      end

      // zero-fill on growing set_size
      S_FILL: begin
        if (wp < lim) begin
          mem_we    = 1'b1;
          mem_waddr = wp[ADDR_W-1:0];
          mem_wdata = '0;
          wp_next   = wp_inc;
        end else begin
          count_next  = lim;
          res_ok_next = 1'b1;
          state_next  = S_DONE;
        end
      end

      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next    = 1'b1;
          rsp_next.ok       = res_ok;
          rsp_next.value    = res_value;
          rsp_next.position = res_pos;
          rsp_next.count    = count;
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pend      <= pend_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    elem      <= elem_next;
    idx       <= idx_next;
    lim       <= lim_next;
    rp        <= rp_next;
    wp        <= wp_next;
    pend_addr <= pend_addr_next;
    res_ok    <= res_ok_next;
    res_value <= res_value_next;
    res_pos   <= res_pos_next;
    rsp       <= rsp_next;
  end

endmodule

### sim/list_result_checker.sv
`timescale 1ns / 1ps
// result checker for indexed_list_table_top: predicts each response word of the list
// table from accepted requests and compares it with the block's output; uses ilt_pkg
module list_result_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  ilt_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  ilt_pkg::rsp_t rsp,
  output int            errors,
  output int            owed,
  output int            fill
);
  import ilt_pkg::*;

  logic [ELEMENT_BITS-1:0] list_mem [CAPACITY];
  int                      list_len = 0;
  rsp_t                    owed_q [$];
  rsp_t                    want;
  int                      err_n = 0;

  assign errors = err_n;

  function automatic void drop_span(int at, int gap);
    int i;
    for (i = at; i + gap < list_len; i++) list_mem[i] = list_mem[i + gap];
    list_len -= gap;
  endfunction

  function automatic int find_first(logic [ELEMENT_BITS-1:0] e);
    int i;
    for (i = 0; i < list_len; i++) if (list_mem[i] == e) return i;
    return -1;
  endfunction

  function automatic rsp_t apply_request(req_t w);
    rsp_t                    r;
    int                      i;
    int                      idx;
    int                      fin;
    int                      nsz;
    logic [ELEMENT_BITS-1:0] e;
    r   = '0;
    idx = int'(w.index);
    fin = int'(w.range_end);
    nsz = int'(w.new_size);
    e   = w.element;
    case (w.operation)
      OP_ADD: begin
        if (list_len < CAPACITY) begin
          list_mem[list_len] = e;
          list_len++;
          r.ok = 1'b1;
        end
      end
      OP_INSERT: begin
        if (list_len < CAPACITY && idx <= list_len) begin
          for (i = list_len; i > idx; i--) list_mem[i] = list_mem[i - 1];
          list_mem[idx] = e;
          list_len++;
          r.ok = 1'b1;
        end
      end
      OP_GET: begin
        if (idx < list_len) begin
          r.value = list_mem[idx];
          r.ok = 1'b1;
        end
      end
      OP_SET: begin
        if (idx < list_len) begin
          r.value = list_mem[idx];
          list_mem[idx] = e;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE_AT: begin
        if (idx < list_len) begin
          drop_span(idx, 1);
          r.ok = 1'b1;
        end
      end
      OP_REMOVE_VALUE: begin
        i = find_first(e);
        if (i >= 0) begin
          drop_span(i, 1);
          r.ok = 1'b1;
        end
      end
      OP_REMOVE_RANGE: begin
        if (idx < fin && fin <= list_len) begin
          drop_span(idx, fin - idx);
          r.ok = 1'b1;
        end
      end
      OP_FIRST_INDEX: begin
        i = find_first(e);
        r.position = CNT_W'((i >= 0) ? i : list_len);
        r.ok = (i >= 0);
      end
      OP_LAST_INDEX: begin
        r.position = CNT_W'(list_len);
        for (i = list_len - 1; i >= 0; i--) begin
          if (list_mem[i] == e) begin
            r.position = CNT_W'(i);
            r.ok = 1'b1;
            break;
          end
        end
      end
      OP_CONTAINS: begin
        r.ok = (find_first(e) >= 0);
      end
      OP_CLEAR: begin
        list_len = 0;
        r.ok = 1'b1;
      end
      OP_SET_SIZE: begin
        if (nsz < list_len) begin
          list_len = nsz;
          r.ok = 1'b1;
        end else if (nsz <= CAPACITY) begin
          for (i = list_len; i < nsz; i++) list_mem[i] = '0;
          list_len = nsz;
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(list_len);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      list_len = 0;
      owed_q.delete();
    end else begin
      // a response can never belong to a request taken at the same edge
      if (rsp_valid && !rsp_stall) begin
        if (owed_q.size() == 0) begin
          err_n++;
          $display("%0t: unexpected response word, expected none, %s",
                   $time, "got");
          $display("  ok=%0d value=%h pos=%0d count=%0d",
                   rsp.ok, rsp.value, rsp.position, rsp.count);
        end else begin
          want = owed_q.pop_front();
          if (rsp.ok !== want.ok || rsp.value !== want.value ||
              rsp.position !== want.position || rsp.count !== want.count) begin
            err_n++;
            $display("%0t: mismatch, expected ok=%0d value=%h pos=%0d count=%0d,",
                     $time, want.ok, want.value, want.position, want.count);
            $display("  got ok=%0d value=%h pos=%0d count=%0d",
                     rsp.ok, rsp.value, rsp.position, rsp.count);
          end
        end
      end
      if (req_valid && !req_stall) owed_q.push_back(apply_request(req));
    end
    owed <= owed_q.size();
    fill <= list_len;
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// testbench top for indexed_list_table_top: directed and random request words with
// random idling on both channels; depends on ilt_pkg and list_result_checker
module tb_top;
  import ilt_pkg::*;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  logic quiet     = 1'b0;
  req_t req       = '0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;
  int   errors;
  int   owed;
  int   fill;

  always #4 clk = ~clk;

  indexed_list_table_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  list_result_checker chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .owed      (owed),
    .fill      (fill)
  );

  always @(posedge clk) begin
    rsp_stall <= !quiet && ($urandom_range(0, 99) < 7);
  end

  task automatic send_word(req_t w);
    if (!quiet && $urandom_range(0, 99) < 7) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic put(logic [OP_W-1:0] op, int idx, int fin, int nsz,
                     logic [ELEMENT_BITS-1:0] e);
    req_t w;
    w.operation = op;
    w.index     = CNT_W'(idx);
    w.range_end = CNT_W'(fin);
    w.new_size  = CNT_W'(nsz);
    w.element   = e;
    send_word(w);
  endtask

  // hold off until every response has come back
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
  endtask

  function automatic logic [ELEMENT_BITS-1:0] pick_element();
    if ($urandom_range(0, 99) < 40) return ELEMENT_BITS'($urandom);
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'h0002;
      3: return 16'h0003;
      4: return 16'hffff;
      5: return 16'h8000;
      6: return 16'h5555;
      default: return 16'haaaa;
    endcase
  endfunction

  // mode 0 grows the list, 1 keeps it level, 2 shrinks it
  function automatic req_t make_word(int mode);
    req_t w;
    int   hint;
    int   roll;
    int   idx;
    int   fin;
    int   add_pct;
    hint    = fill;
    add_pct = (mode == 0) ? 35 : (mode == 1) ? 12 : 3;
    if ($urandom_range(0, 99) < add_pct) begin
      w.operation = OP_ADD;
    end else begin
      roll = $urandom_range(0, 99);
      if      (roll < 14) w.operation = OP_INSERT;
      else if (roll < 26) w.operation = OP_GET;
      else if (roll < 36) w.operation = OP_SET;
      else if (roll < 46) w.operation = OP_REMOVE_AT;
      else if (roll < 56) w.operation = OP_REMOVE_VALUE;
      else if (roll < 63) w.operation = OP_REMOVE_RANGE;
      else if (roll < 71) w.operation = OP_FIRST_INDEX;
      else if (roll < 79) w.operation = OP_LAST_INDEX;
      else if (roll < 87) w.operation = OP_CONTAINS;
      else if (roll < 90) w.operation = OP_CLEAR;
      else if (roll < 97) w.operation = OP_SET_SIZE;
      else w.operation = OP_SET_SIZE + OP_W'($urandom_range(1, 4));
    end
    if ($urandom_range(0, 99) < 85) idx = $urandom_range(0, (hint < CAPACITY) ? hint + 1 : hint);
    else idx = $urandom_range(0, CAPACITY);
    roll = $urandom_range(0, 99);
    if (roll < 50) fin = idx + $urandom_range(0, 6);
    else if (roll < 70) fin = hint;
    else fin = $urandom_range(0, CAPACITY);
    if (fin > CAPACITY) fin = CAPACITY;
    w.index     = CNT_W'(idx);
    w.range_end = CNT_W'(fin);
    if ($urandom_range(0, 99) < 60)
      w.new_size = CNT_W'($urandom_range(0, (hint + 4 > CAPACITY) ? CAPACITY : hint + 4));
    else
      w.new_size = CNT_W'($urandom_range(0, CAPACITY));
    w.element = pick_element();
    return w;
  endfunction

  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty list corners
    put(OP_GET, 0, 0, 0, 16'h0000);
    put(OP_FIRST_INDEX, 0, 0, 0, 16'h0000);
    put(OP_LAST_INDEX, 0, 0, 0, 16'hffff);
    put(OP_REMOVE_AT, 0, 0, 0, 16'h0000);
    // grow to capacity with zeros, then overflow attempts
    put(OP_SET_SIZE, 0, 0, CAPACITY, 16'h1234);
    put(OP_ADD, 0, 0, 0, 16'h0001);
    put(OP_INSERT, 0, 0, 0, 16'h0002);
    put(OP_SET_SIZE, 0, 0, 100, 16'h0000);
    put(OP_SET_SIZE, 0, 0, 127, 16'hffff);
    put(OP_GET, CAPACITY - 1, 0, 0, 16'h0000);
    put(OP_SET, CAPACITY - 1, 0, 0, 16'hffff);
    put(OP_LAST_INDEX, 0, 0, 0, 16'hffff);
    put(OP_FIRST_INDEX, 0, 0, 0, 16'h0000);
    // range end equal to count, then empty range
    put(OP_REMOVE_RANGE, 1, CAPACITY, 0, 16'h0000);
    put(OP_REMOVE_RANGE, 0, 0, 0, 16'h0000);
    // insert above count fails, at count appends
    put(OP_INSERT, 2, 0, 0, 16'h7777);
    put(OP_INSERT, 1, 0, 0, 16'haaaa);
    put(OP_INSERT, 0, 0, 0, 16'h5555);
    put(OP_REMOVE_VALUE, 0, 0, 0, 16'haaaa);
    put(OP_CONTAINS, 0, 0, 0, 16'h5555);
    put(OP_CONTAINS, 0, 0, 0, 16'h1234);
    put(OP_REMOVE_AT, 5, 0, 0, 16'h0000);
    put(OP_SET_SIZE + OP_W'(1), 127, 127, 127, 16'hffff);
    put(OP_SET_SIZE + OP_W'(4), 127, 127, 127, 16'hffff);
    put(OP_SET_SIZE, 0, 0, 0, 16'h0000);
    put(OP_CLEAR, 0, 0, 0, 16'h0000);
    put(OP_ADD, 0, 0, 0, 16'hffff);
    put(OP_GET, 127, 0, 0, 16'h0000);
    drain();

    for (k = 0; k < 2000; k++) begin
      if (k == 800) quiet <= 1'b1;
      if (k == 1100) quiet <= 1'b0;
      if (k == 1000) drain();
      send_word(make_word((k / 250) % 3));
    end
    drain();
    repeat (150) @(posedge clk);

    if (errors == 0 && owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
src/ilt_pkg.sv
src/indexed_list_table_top.sv
sim/list_result_checker.sv
sim/tb_top.sv
